/* rtl/core/rsmq_pkg.sv */
// Shared types and constants for the repeat send message queue.
// Payload structs for the command and result words, codes and defaults.
// No dependencies.
package rsmq_pkg;

    localparam int QUEUE_DEPTH_C   = 8;
    localparam int MAX_MSG_BYTES_C = 32;
    localparam int TICK_DIVISOR_C  = 5;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SEND   = 1'b1;

    // enqueue status codes
    localparam logic [1:0] ENQ_ACCEPTED = 2'd0;
    localparam logic [1:0] ENQ_FULL     = 2'd1;
    localparam logic [1:0] ENQ_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIND,
        ST_COPY,
        ST_SCAN,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [7:0]  repeat_count;
        logic        reliable_flag;
        logic [31:0] tick_value;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [1:0] enqueue_status;
        logic [2:0] slot_index;
        logic       send_reliable;
        logic [7:0] send_byte;
        logic [5:0] send_length;
        logic [7:0] repeats_left;
        logic       result_last;
    } t_out_item;

endpackage

/* rtl/core/rsmq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Used for the message holding buffer and the slot message store. No dependencies.
module rsmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rsmq_mod_unit.sv */
// Residue unit: tests a 32-bit tick count for divisibility by a constant divisor.
// Sums per-bit residues four bits a cycle, then folds the sum with compare and
// subtract steps before raising done. Depends on nothing else.
module rsmq_mod_unit #(
    parameter int TICK_DIVISOR = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    output logic        o_done,
    output logic        o_zero
);

    // residue sum of all 32 bits stays below 32 * TICK_DIVISOR
    localparam int SW = $clog2(32 * TICK_DIVISOR + 1);
    localparam logic [3:0]    ACC_LAST = 4'd7;
    localparam logic [3:0]    RUN_LAST = 4'd12;
    localparam logic [SW-1:0] D1_C  = SW'(TICK_DIVISOR);
    localparam logic [SW-1:0] D2_C  = SW'(2 * TICK_DIVISOR);
    localparam logic [SW-1:0] D4_C  = SW'(4 * TICK_DIVISOR);
    localparam logic [SW-1:0] D8_C  = SW'(8 * TICK_DIVISOR);
    localparam logic [SW-1:0] D16_C = SW'(16 * TICK_DIVISOR);

    function automatic int pow2_mod(int pos);
        int v;
        v = 1 % TICK_DIVISOR;
        for (int k = 0; k < pos; k++) begin
            v = (v * 2) % TICK_DIVISOR;
        end
        return v;
    endfunction

    logic [SW-1:0] w_pow [32];
    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [31:0]   r_shift;
    logic [SW-1:0] r_acc;
    logic [SW-1:0] n_acc;
    logic [SW-1:0] sub_c;

    // residue of each bit weight
    for (genvar g = 0; g < 32; g++) begin : g_pow
        localparam int POW_C = pow2_mod(g);
        assign w_pow[g] = SW'(POW_C);
    end

    always_comb begin
        case (r_cnt)
            4'd8:    sub_c = D16_C;
            4'd9:    sub_c = D8_C;
            4'd10:   sub_c = D4_C;
            4'd11:   sub_c = D2_C;
            default: sub_c = D1_C;
        endcase
    end

    // first eight steps add nibble residues, the rest fold the sum below the divisor
    always_comb begin
        n_acc = r_acc;
        if (r_cnt <= ACC_LAST) begin
            for (int b = 0; b < 4; b++) begin
                if (r_shift[b]) begin
                    n_acc = n_acc + w_pow[{r_cnt[2:0], 2'(b)}];
                end
            end
        end else if (r_acc >= sub_c) begin
            n_acc = r_acc - sub_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 4'd1;
            r_busy <= (r_cnt != RUN_LAST);
            r_done <= (r_cnt == RUN_LAST);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_shift <= {4'd0, r_shift[31:4]};
            r_acc   <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_acc == '0);

endmodule

/* rtl/core/repeat_send_message_queue_unit.sv */
// Repeat send message queue, top level: slot table, sequencer and result register.
// Depends on rsmq_pkg, rsmq_ram and rsmq_mod_unit.
//
// A message byte word is taken whenever busy is low; busy stays low while a message is
// being gathered, so bytes may arrive back to back. The last byte of a message that
// is not too long starts the sequencer: a slot search, a copy of the held message
// into the slot store, then a send scan that sends the first pending message, if any.
// A message that is too long, or that finds no free slot, gives a status result only.
// A tick word runs the remainder unit and starts the send scan if the tick value is
// divisible by TICK_DIVISOR. The slot store and holding buffer are RAMs with one
// write port and one registered read port that move one byte per cycle. Results are
// presented for exactly one cycle on o_result with o_strobe high and cannot be held
// off by the receiver.
module repeat_send_message_queue_unit #(
    parameter int QUEUE_DEPTH   = rsmq_pkg::QUEUE_DEPTH_C,
    parameter int MAX_MSG_BYTES = rsmq_pkg::MAX_MSG_BYTES_C,
    parameter int TICK_DIVISOR  = rsmq_pkg::TICK_DIVISOR_C
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rsmq_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output rsmq_pkg::t_out_item o_result
);

    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int MW          = $clog2(MAX_MSG_BYTES);
    localparam int CW          = $clog2(MAX_MSG_BYTES + 2);
    localparam int LW          = $clog2(MAX_MSG_BYTES + 1);
    localparam int STORE_DEPTH = QUEUE_DEPTH << MW;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_MSG_BYTES);
    localparam logic [QW-1:0] LAST_Q = QW'(QUEUE_DEPTH - 1);

    rsmq_pkg::t_state r_state, n_state;

    logic [7:0]    r_rep [QUEUE_DEPTH];
    logic          r_rel [QUEUE_DEPTH];
    logic [LW-1:0] r_len [QUEUE_DEPTH];

    logic [QW-1:0] r_sp;
    logic [QW-1:0] r_scan;
    logic [QW-1:0] r_steps;
    logic [QW-1:0] r_found;
    logic [CW-1:0] r_fill_cnt;
    logic          r_fill_open;
    logic [7:0]    r_new_reps;
    logic          r_new_rel;
    logic [CW-1:0] r_idx;
    logic          r_cp_vld;
    logic [MW-1:0] r_cp_j;
    logic [LW-1:0] r_cur_len;
    logic          r_cur_rel;
    logic [7:0]    r_cur_left;
    logic          r_ovld;
    rsmq_pkg::t_out_item r_out;

    logic          accept;
    logic [CW-1:0] eff_cnt;
    logic [CW-1:0] new_cnt;
    logic          too_long;
    logic [QW-1:0] rep_idx;
    logic [7:0]    rep_cur;
    logic          rep_zero;
    logic          scan_last;
    logic          copy_end;
    logic          send_end;
    logic          hold_we;
    logic          mod_start;
    logic          mod_done;
    logic          mod_zero;
    logic          store_we;
    logic [7:0]    hold_rdata;
    logic [7:0]    store_rdata;

    function automatic rsmq_pkg::t_out_item status_word(logic [1:0] status, logic [2:0] slot,
                                                        logic last);
        rsmq_pkg::t_out_item w;
        w                = '0;
        w.out_kind       = rsmq_pkg::KIND_STATUS;
        w.enqueue_status = status;
        w.slot_index     = slot;
        w.result_last    = last;
        return w;
    endfunction

    assign busy     = (r_state != rsmq_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign eff_cnt  = r_fill_open ? r_fill_cnt : '0;
    assign new_cnt  = (eff_cnt <= MAX_C) ? eff_cnt + CW'(1) : eff_cnt;
    assign too_long = (new_cnt > MAX_C);
    assign hold_we  = accept && (i_item.req_type == rsmq_pkg::REQ_BYTE) && (eff_cnt < MAX_C);
    assign mod_start = accept && (i_item.req_type == rsmq_pkg::REQ_TICK);

    assign rep_idx   = (r_state == rsmq_pkg::ST_FIND) ? r_scan : r_sp;
    assign rep_cur   = r_rep[rep_idx];
    assign rep_zero  = (rep_cur == 8'd0);
    assign scan_last = (r_steps == LAST_Q);
    assign copy_end  = (r_idx == r_fill_cnt);
    assign send_end  = (r_idx + CW'(1) == CW'(r_cur_len));
    assign store_we  = (r_state == rsmq_pkg::ST_COPY) && r_cp_vld;

    rsmq_mod_unit #(
        .TICK_DIVISOR(TICK_DIVISOR)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_item.tick_value),
        .o_done     (mod_done),
        .o_zero     (mod_zero)
    );

    rsmq_ram #(
        .WIDTH(8),
        .DEPTH(MAX_MSG_BYTES)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (hold_we),
        .i_waddr (eff_cnt[MW-1:0]),
        .i_wdata (i_item.data_byte),
        .i_raddr (r_idx[MW-1:0]),
        .o_rdata (hold_rdata)
    );

    rsmq_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr ({r_found, r_cp_j}),
        .i_wdata (hold_rdata),
        .i_raddr ({r_sp, r_idx[MW-1:0]}),
        .o_rdata (store_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsmq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsmq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_item.req_type == rsmq_pkg::REQ_TICK) begin
                        n_state = rsmq_pkg::ST_DIV;
                    end else if (i_item.byte_last && !too_long) begin
                        n_state = rsmq_pkg::ST_FIND;
                    end
                end
            end
            rsmq_pkg::ST_DIV: begin
                if (mod_done) begin
                    n_state = mod_zero ? rsmq_pkg::ST_SCAN : rsmq_pkg::ST_IDLE;
                end
            end
            rsmq_pkg::ST_FIND: begin
                if (rep_zero) begin
                    n_state = rsmq_pkg::ST_COPY;
                end else if (scan_last) begin
                    n_state = rsmq_pkg::ST_IDLE;
                end
            end
            rsmq_pkg::ST_COPY: begin
                if (copy_end) begin
                    n_state = rsmq_pkg::ST_SCAN;
                end
            end
            rsmq_pkg::ST_SCAN: begin
                if (!rep_zero) begin
                    n_state = rsmq_pkg::ST_SEND;
                end else if (scan_last) begin
                    n_state = rsmq_pkg::ST_IDLE;
                end
            end
            rsmq_pkg::ST_SEND: begin
                if (send_end) begin
                    n_state = rsmq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsmq_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_rep[i] <= 8'd0;
                r_rel[i] <= 1'b0;
            end
            r_sp        <= '0;
            r_fill_cnt  <= '0;
            r_fill_open <= 1'b0;
            r_cp_vld    <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            case (r_state)
                rsmq_pkg::ST_IDLE: begin
                    r_ovld <= accept && (i_item.req_type == rsmq_pkg::REQ_BYTE) &&
                              i_item.byte_last && too_long;
                    if (accept && (i_item.req_type == rsmq_pkg::REQ_BYTE)) begin
                        r_fill_cnt  <= new_cnt;
                        r_fill_open <= !i_item.byte_last;
                    end
                end
                rsmq_pkg::ST_FIND: begin
                    r_cp_vld <= 1'b0;
                    r_ovld   <= !rep_zero && scan_last;
                end
                rsmq_pkg::ST_COPY: begin
                    r_cp_vld <= !copy_end;
                    r_ovld   <= copy_end;
                    if (copy_end) begin
                        r_rep[r_found] <= r_new_reps;
                        r_rel[r_found] <= r_new_rel;
                    end
                end
                rsmq_pkg::ST_SCAN: begin
                    r_ovld <= 1'b0;
                    if (!rep_zero) begin
                        r_rep[r_sp] <= rep_cur - 8'd1;
                    end else begin
                        r_sp <= (r_sp == LAST_Q) ? '0 : r_sp + QW'(1);
                    end
                end
                rsmq_pkg::ST_SEND: begin
                    r_ovld <= 1'b1;
                end
                default: begin
                    r_cp_vld <= 1'b0;
                    r_ovld   <= 1'b0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rsmq_pkg::ST_IDLE: begin
                r_scan  <= r_sp;
                r_steps <= '0;
                r_idx   <= '0;
                r_out   <= status_word(rsmq_pkg::ENQ_TOO_LONG, 3'd0, 1'b1);
                if (i_item.reliable_flag || (i_item.repeat_count == 8'd0)) begin
                    r_new_reps <= 8'd1;
                end else begin
                    r_new_reps <= i_item.repeat_count;
                end
                r_new_rel <= i_item.reliable_flag;
            end
            rsmq_pkg::ST_DIV: begin
                r_steps <= '0;
            end
            rsmq_pkg::ST_FIND: begin
                r_found <= r_scan;
                r_idx   <= '0;
                r_scan  <= (r_scan == LAST_Q) ? '0 : r_scan + QW'(1);
                r_steps <= r_steps + QW'(1);
                r_out   <= status_word(rsmq_pkg::ENQ_FULL, 3'd0, 1'b1);
            end
            rsmq_pkg::ST_COPY: begin
                if (copy_end) begin
                    r_len[r_found] <= r_fill_cnt[LW-1:0];
                    r_steps        <= '0;
                    r_out          <= status_word(rsmq_pkg::ENQ_ACCEPTED, 3'(r_found), 1'b0);
                end else begin
                    r_cp_j <= r_idx[MW-1:0];
                    r_idx  <= r_idx + CW'(1);
                end
            end
            rsmq_pkg::ST_SCAN: begin
                r_steps    <= r_steps + QW'(1);
                r_idx      <= '0;
                r_cur_left <= rep_cur - 8'd1;
                r_cur_rel  <= r_rel[r_sp];
                r_cur_len  <= r_len[r_sp];
            end
            rsmq_pkg::ST_SEND: begin
                r_idx <= r_idx + CW'(1);
                r_out.out_kind       <= rsmq_pkg::KIND_SEND;
                r_out.enqueue_status <= rsmq_pkg::ENQ_ACCEPTED;
                r_out.slot_index     <= 3'(r_sp);
                r_out.send_reliable  <= r_cur_rel;
                r_out.send_byte      <= 8'd0;
                r_out.send_length    <= 6'(r_cur_len);
                r_out.repeats_left   <= r_cur_left;
                r_out.result_last    <= send_end;
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    // send bytes come straight from the store read register
    always_comb begin
        o_result = r_out;
        if (r_out.out_kind == rsmq_pkg::KIND_SEND) begin
            o_result.send_byte = store_rdata;
        end
    end

    assign o_strobe = r_ovld;

endmodule

/* verif/tb.sv */
// Self-checking testbench for repeat_send_message_queue_unit: byte and tick words in,
// status and send results checked in order against a class-based scoreboard.
// Depends on rsmq_pkg and the RTL top level only.
module tb;
    import rsmq_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_WORDS = 210;

    class msg_queue_scoreboard;
        logic [7:0] slot_left [QUEUE_DEPTH_C];
        logic       slot_rel  [QUEUE_DEPTH_C];
        logic [5:0] slot_len  [QUEUE_DEPTH_C];
        logic [7:0] slot_data [QUEUE_DEPTH_C][MAX_MSG_BYTES_C];
        logic [7:0] stage_buf [MAX_MSG_BYTES_C];
        logic [2:0] scan_ptr;
        logic [5:0] open_count;
        logic       msg_open;
        t_out_item  due_results [$];
        t_out_item  held;
        bit         have_held;
        int         errors;
        int         n_checked;

        function new();
            for (int s = 0; s < QUEUE_DEPTH_C; s++) begin
                slot_left[s] = '0;
                slot_rel[s]  = 1'b0;
                slot_len[s]  = '0;
            end
            scan_ptr   = '0;
            open_count = '0;
            msg_open   = 1'b0;
            have_held  = 1'b0;
            errors     = 0;
            n_checked  = 0;
        endfunction

        // Hold back the newest result so the last one of a word can be flagged.
        function void push_result(logic kind, logic [1:0] status, logic [2:0] slot,
                                  logic rel, logic [7:0] data, logic [5:0] len,
                                  logic [7:0] left);
            t_out_item r;
            r.out_kind       = kind;
            r.enqueue_status = status;
            r.slot_index     = slot;
            r.send_reliable  = rel;
            r.send_byte      = data;
            r.send_length    = len;
            r.repeats_left   = left;
            r.result_last    = 1'b0;
            if (have_held)
                due_results.push_back(held);
            held      = r;
            have_held = 1'b1;
        endfunction

        function void close_word();
            if (have_held) begin
                held.result_last = 1'b1;
                due_results.push_back(held);
                have_held = 1'b0;
            end
        endfunction

        // Skip empty slots from the pointer; send the first pending one once.
        function void serve_queue();
            logic [2:0] p;
            for (int i = 0; i < QUEUE_DEPTH_C; i++) begin
                p = scan_ptr;
                if (slot_left[p] != 0) begin
                    slot_left[p] = slot_left[p] - 1'b1;
                    for (int j = 0; j < slot_len[p]; j++)
                        push_result(KIND_SEND, ENQ_ACCEPTED, p, slot_rel[p],
                                    slot_data[p][j], slot_len[p], slot_left[p]);
                    return;
                end
                scan_ptr = 3'((p + 1) % QUEUE_DEPTH_C);
            end
        endfunction

        function void note_word(t_in_item w);
            logic [2:0] slot;
            logic [7:0] reps;
            bit         found;
            if (w.req_type == REQ_TICK) begin
                if (w.tick_value % TICK_DIVISOR_C == 0)
                    serve_queue();
            end else begin
                if (!msg_open) begin
                    open_count = '0;
                    msg_open   = 1'b1;
                end
                if (open_count < MAX_MSG_BYTES_C)
                    stage_buf[open_count] = w.data_byte;
                // saturate one past the limit so an overlong message is remembered
                if (open_count <= MAX_MSG_BYTES_C)
                    open_count = open_count + 1'b1;
                if (w.byte_last) begin
                    msg_open = 1'b0;
                    if (open_count > MAX_MSG_BYTES_C) begin
                        push_result(KIND_STATUS, ENQ_TOO_LONG, '0, 1'b0, '0, '0, '0);
                    end else begin
                        found = 1'b0;
                        slot  = scan_ptr;
                        for (int i = 0; i < QUEUE_DEPTH_C && !found; i++) begin
                            slot  = 3'((scan_ptr + i) % QUEUE_DEPTH_C);
                            found = (slot_left[slot] == 0);
                        end
                        if (!found) begin
                            push_result(KIND_STATUS, ENQ_FULL, '0, 1'b0, '0, '0, '0);
                        end else begin
                            reps = w.reliable_flag ? 8'd1 : w.repeat_count;
                            if (reps == 0)
                                reps = 8'd1;
                            slot_rel[slot]  = w.reliable_flag;
                            slot_left[slot] = reps;
                            slot_len[slot]  = open_count;
                            for (int j = 0; j < open_count; j++)
                                slot_data[slot][j] = stage_buf[j];
                            push_result(KIND_STATUS, ENQ_ACCEPTED, slot, 1'b0, '0, '0, '0);
                            serve_queue();
                        end
                    end
                end
            end
            close_word();
        endfunction

        task report_mismatch(string text);
            $display("MISMATCH at %0t: %s", $time, text);
            errors++;
        endtask

        task compare_field(string name, int idx, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                          idx, name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing due: %h", n_checked, got));
            end else begin
                want = due_results.pop_front();
                compare_field("out_kind", n_checked, got.out_kind, want.out_kind);
                compare_field("enqueue_status", n_checked, got.enqueue_status,
                              want.enqueue_status);
                compare_field("slot_index", n_checked, got.slot_index, want.slot_index);
                compare_field("send_reliable", n_checked, got.send_reliable,
                              want.send_reliable);
                compare_field("send_byte", n_checked, got.send_byte, want.send_byte);
                compare_field("send_length", n_checked, got.send_length, want.send_length);
                compare_field("repeats_left", n_checked, got.repeats_left, want.repeats_left);
                compare_field("result_last", n_checked, got.result_last, want.result_last);
            end
            n_checked++;
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_strobe;
    t_in_item  i_item;
    t_out_item o_result;

    msg_queue_scoreboard sb;
    int stall_cycles = 0;
    int quiet_run    = 0;
    int n_words      = 0;

    repeat_send_message_queue_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results seen at an edge belong to earlier words, so check before noting.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_word(i_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** repeat_send_message_queue_unit: FAILED **");
            $finish;
        end
    end

    function automatic t_in_item byte_word(logic [7:0] data, logic last, logic [7:0] rep,
                                           logic rel);
        t_in_item w;
        w.req_type      = REQ_BYTE;
        w.data_byte     = data;
        w.byte_last     = last;
        w.repeat_count  = rep;
        w.reliable_flag = rel;
        w.tick_value    = $urandom;
        return w;
    endfunction

    function automatic t_in_item tick_word(logic [31:0] value);
        t_in_item w;
        w.req_type      = REQ_TICK;
        w.data_byte     = $urandom_range(0, 255);
        w.byte_last     = $urandom_range(0, 1);
        w.repeat_count  = $urandom_range(0, 255);
        w.reliable_flag = $urandom_range(0, 1);
        w.tick_value    = value;
        return w;
    endfunction

    function automatic logic [31:0] pick_tick();
        if ($urandom_range(0, 9) < 7)
            return TICK_DIVISOR_C * $urandom_range(0, 32'hFFFF_FFFF / TICK_DIVISOR_C);
        return $urandom;
    endfunction

    // Mostly random gaps, with occasional back-to-back stretches.
    function automatic int pick_gap();
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet_run = $urandom_range(5, 30);
        return $urandom_range(0, 18);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic drive_word(t_in_item w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        n_words++;
    endtask

    task automatic send_message(int len, logic [7:0] rep, logic rel);
        logic last;
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                drive_word(tick_word(pick_tick()));
            last = (i == len - 1);
            drive_word(byte_word($urandom_range(0, 255), last,
                                 last ? rep : 8'($urandom_range(0, 255)),
                                 last ? rel : 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic send_random_message();
        int   pick;
        int   len;
        logic rel;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(1, 6);
        else if (pick < 85)
            len = $urandom_range(7, MAX_MSG_BYTES_C - 1);
        else if (pick < 92)
            len = MAX_MSG_BYTES_C;
        else
            len = $urandom_range(MAX_MSG_BYTES_C + 1, MAX_MSG_BYTES_C + 4);
        rel = ($urandom_range(0, 2) == 0);
        // keep unreliable repeats low so one slot does not hog the sender
        send_message(len, rel ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)), rel);
    endtask

    initial begin
        int base;
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ticks on an empty queue
        drive_word(tick_word(32'd1));
        drive_word(tick_word(32'd0));
        // zero repeats taken as one; reliable forces one
        drive_word(byte_word(8'h00, 1'b1, 8'd0, 1'b0));
        drive_word(byte_word(8'hFF, 1'b1, 8'd255, 1'b1));
        // tick in the middle of an open message
        drive_word(byte_word(8'hAA, 1'b0, 8'h5A, 1'b1));
        drive_word(tick_word(32'd5));
        drive_word(byte_word(8'h55, 1'b0, 8'hA5, 1'b0));
        drive_word(byte_word(8'h0F, 1'b1, 8'd3, 1'b0));
        drive_word(tick_word(32'hFFFF_FFFF));
        drive_word(tick_word(32'd10));
        // fill every slot, then overflow
        drive_word(byte_word(8'h81, 1'b1, 8'd9, 1'b0));
        for (int i = 0; i < QUEUE_DEPTH_C - 1; i++)
            drive_word(byte_word($urandom_range(0, 255), 1'b1, (i == 0) ? 8'd0 : 8'd1,
                                 (i == 0)));
        drive_word(byte_word(8'h7E, 1'b1, 8'd4, 1'b0));
        drive_word(tick_word(32'd15));
        drive_word(tick_word(32'd20));

        base = n_words;
        for (int k = 0; n_words - base < RANDOM_WORDS; k++) begin
            if (k == 0)
                send_message(MAX_MSG_BYTES_C + 1, 8'd2, 1'b0);
            else if (k == 6)
                send_message(MAX_MSG_BYTES_C, 8'd2, 1'b0);
            else if ($urandom_range(0, 99) < 35)
                drive_word(tick_word(pick_tick()));
            else
                send_random_message();
        end
        start <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("** repeat_send_message_queue_unit: PASSED **");
        else
            $display("** repeat_send_message_queue_unit: FAILED **");
        $finish;
    end

endmodule
